// ===== rtl/core/prefix_version_table_lookup_defines.svh =====
// Assertion macros shared by the table lookup RTL.
// Each macro expects signals named clk and rst_n in the calling module.
`ifndef PREFIX_VERSION_TABLE_LOOKUP_DEFINES_SVH
`define PREFIX_VERSION_TABLE_LOOKUP_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define PVTL_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pvtl assertion failed");

// Next-cycle implication, checked out of reset
`define PVTL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pvtl assertion failed");

`endif

// ===== rtl/core/pvtl_pkg.sv =====
// Package for the prefix/version table lookup: sizes, op codes, mask helper.
// No dependencies.
package pvtl_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int IDX_W       = 8;
    localparam int KEY_W       = 64;
    localparam int VER_W       = 64;
    localparam int ENTRY_W     = KEY_W + VER_W;

    localparam logic [2:0] OP_WRITE    = 3'd0;
    localparam logic [2:0] OP_PREFIX   = 3'd1;
    localparam logic [2:0] OP_EXACT    = 3'd2;
    localparam logic [2:0] OP_AT_LEAST = 3'd3;
    localparam logic [2:0] OP_AT_MOST  = 3'd4;

    // Byte mask covering the leading plen bytes, plen clamped to 8
    function automatic logic [KEY_W-1:0] prefix_mask(input logic [3:0] plen);
        logic [3:0] nbytes;
        logic [KEY_W-1:0] m;
        nbytes = (plen > 4'd8) ? 4'd8 : plen;
        if (nbytes == 4'd0)
        begin
            m = '0;
        end
        else
        begin
            m = {KEY_W{1'b1}} << (7'd64 - {nbytes, 3'b000});
        end
        return m;
    endfunction

endpackage

// ===== rtl/core/pvtl_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pvtl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/prefix_version_table_lookup.sv =====
// Prefix/version table lookup top level: control, scan logic and output register.
// Depends on pvtl_pkg, pvtl_ram and prefix_version_table_lookup_defines.svh.
//
// A write (op 0) or an unused op goes from S_IDLE to S_DONE and back to
// S_IDLE. A lookup walks the table entries from index 0 upward, one RAM
// read per cycle, in S_SCAN; the exact-version and at-or-below lookups stop
// at their first hit. The result word sits in an output register, so a new
// word is accepted while the previous result waits for out_ready. The scan
// rate is set by the single read port of the entry RAM. Table contents are
// undefined until written; the user writes entry_count through cfg_we/cfg_data
// only while idle, which the block itself does not enforce.
`include "prefix_version_table_lookup_defines.svh"

module prefix_version_table_lookup (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration
    input  logic                          cfg_we,
    input  logic [8:0]                    cfg_data,
    // input word
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [2:0]                    op,
    input  logic [pvtl_pkg::IDX_W-1:0]    entry_index,
    input  logic [pvtl_pkg::KEY_W-1:0]    key_prefix,
    input  logic [3:0]                    prefix_len,
    input  logic signed [pvtl_pkg::VER_W-1:0] key_version,
    // result word
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          found,
    output logic [pvtl_pkg::IDX_W-1:0]    match_index
);

    import pvtl_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    // control registers
    logic [1:0]        state_reg, state_next;
    logic [8:0]        cnt_reg, cnt_next;
    logic [CNT_W-1:0]  rd_addr_reg, rd_addr_next;
    logic              rd_pend_reg, rd_pend_next;
    logic              stop_reg, stop_next;
    logic              hit_reg, hit_next;
    logic              out_valid_reg, out_valid_next;

    // payload registers
    logic [2:0]               op_reg, op_next;
    logic [KEY_W-1:0]         key_reg, key_next;
    logic [KEY_W-1:0]         mask_reg, mask_next;
    logic signed [VER_W-1:0]  ver_reg, ver_next;
    logic [CNT_W-1:0]         limit_reg, limit_next;
    logic [ADDR_W-1:0]        rd_idx_reg, rd_idx_next;
    logic [ADDR_W-1:0]        best_reg, best_next;
    logic signed [VER_W-1:0]  best_ver_reg, best_ver_next;
    logic                     res_found_reg, res_found_next;
    logic [IDX_W-1:0]         res_index_reg, res_index_next;
    logic                     found_reg, found_next;
    logic [IDX_W-1:0]         match_index_reg, match_index_next;

    // RAM ports
    logic                     ram_we;
    logic                     ram_re;
    logic [ENTRY_W-1:0]       ram_rdata;
    logic [KEY_W-1:0]         rd_key;
    logic signed [VER_W-1:0]  rd_ver;

    logic accept;
    logic scan_end;
    logic take;
    logic key_eq;
    logic pfx_eq;
    logic better;
    logic [CNT_W-1:0] limit_in;

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign ram_we    = accept && (op == OP_WRITE) && (32'(entry_index) < TABLE_DEPTH);
    assign ram_re    = (state_reg == S_SCAN) && !stop_reg && (rd_addr_reg < limit_reg);
    assign scan_end  = (state_reg == S_SCAN) && !rd_pend_reg
                       && (stop_reg || (rd_addr_reg >= limit_reg));

    // searched entries: entry_count clamped to the table depth
    assign limit_in  = (32'(cnt_reg) > TABLE_DEPTH) ? CNT_W'(TABLE_DEPTH) : CNT_W'(cnt_reg);

    pvtl_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ADDR_W'(entry_index)),
        .wdata ({key_prefix, key_version}),
        .re    (ram_re),
        .raddr (rd_addr_reg[ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    assign rd_key = ram_rdata[ENTRY_W-1:VER_W];
    assign rd_ver = $signed(ram_rdata[VER_W-1:0]);

    // match test on the word returned by the RAM
    assign key_eq = (rd_key == key_reg);
    assign pfx_eq = (((rd_key ^ key_reg) & mask_reg) == '0);
    assign better = !hit_reg || (rd_ver > best_ver_reg);

    always_comb
    begin
        case (op_reg)
            OP_PREFIX:   take = pfx_eq && better;
            OP_EXACT:    take = key_eq && (rd_ver == ver_reg);
            OP_AT_LEAST: take = key_eq && (rd_ver >= ver_reg) && better;
            OP_AT_MOST:  take = key_eq && (ver_reg >= rd_ver);
            default:     take = 1'b0;
        endcase
        take = take && rd_pend_reg && !stop_reg;
    end

    // next-state logic
    always_comb
    begin
        state_next       = state_reg;
        cnt_next         = cnt_reg;
        rd_addr_next     = rd_addr_reg;
        rd_pend_next     = 1'b0;
        stop_next        = stop_reg;
        hit_next         = hit_reg;
        out_valid_next   = out_valid_reg;
        op_next          = op_reg;
        key_next         = key_reg;
        mask_next        = mask_reg;
        ver_next         = ver_reg;
        limit_next       = limit_reg;
        rd_idx_next      = rd_idx_reg;
        best_next        = best_reg;
        best_ver_next    = best_ver_reg;
        res_found_next   = res_found_reg;
        res_index_next   = res_index_reg;
        found_next       = found_reg;
        match_index_next = match_index_reg;

        if (cfg_we)
        begin
            cnt_next = cfg_data;
        end

        // output register drains
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next      = op;
                    key_next     = key_prefix;
                    mask_next    = prefix_mask(prefix_len);
                    ver_next     = key_version;
                    limit_next   = limit_in;
                    rd_addr_next = '0;
                    hit_next     = 1'b0;
                    stop_next    = 1'b0;
                    if (op == OP_WRITE)
                    begin
                        res_found_next = 1'b0;
                        res_index_next = entry_index;
                        state_next     = S_DONE;
                    end
                    else if (op inside {[OP_PREFIX:OP_AT_MOST]})
                    begin
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        res_found_next = 1'b0;
                        res_index_next = '0;
                        state_next     = S_DONE;
                    end
                end
            end
            S_SCAN:
            begin
                // issue the next read
                rd_pend_next = ram_re;
                if (ram_re)
                begin
                    rd_addr_next = rd_addr_reg + CNT_W'(1);
                    rd_idx_next  = rd_addr_reg[ADDR_W-1:0];
                end
                // evaluate the returned entry
                if (take)
                begin
                    hit_next      = 1'b1;
                    best_next     = rd_idx_reg;
                    best_ver_next = rd_ver;
                    if ((op_reg == OP_EXACT) || (op_reg == OP_AT_MOST))
                    begin
                        stop_next = 1'b1;
                    end
                end
                if (scan_end)
                begin
                    res_found_next = hit_reg;
                    res_index_next = hit_reg ? IDX_W'(best_reg) : '0;
                    state_next     = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next   = 1'b1;
                    found_next       = res_found_reg;
                    match_index_next = res_index_reg;
                    state_next       = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            rd_addr_reg   <= '0;
            rd_pend_reg   <= 1'b0;
            stop_reg      <= 1'b0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            rd_addr_reg   <= rd_addr_next;
            rd_pend_reg   <= rd_pend_next;
            stop_reg      <= stop_next;
            hit_reg       <= hit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        op_reg          <= op_next;
        key_reg         <= key_next;
        mask_reg        <= mask_next;
        ver_reg         <= ver_next;
        limit_reg       <= limit_next;
        rd_idx_reg      <= rd_idx_next;
        best_reg        <= best_next;
        best_ver_reg    <= best_ver_next;
        res_found_reg   <= res_found_next;
        res_index_reg   <= res_index_next;
        found_reg       <= found_next;
        match_index_reg <= match_index_next;
    end

    assign out_valid   = out_valid_reg;
    assign found       = found_reg;
    assign match_index = match_index_reg;

    // checks
    `PVTL_ASSERT_NEXT(a_accept_leaves_idle, accept, state_reg != S_IDLE)
    `PVTL_ASSERT_IMPL(a_read_in_range, ram_re, rd_addr_reg < limit_reg)
    `PVTL_ASSERT_IMPL(a_best_in_range, hit_reg, CNT_W'(best_reg) < limit_reg)
    `PVTL_ASSERT_IMPL(a_write_on_accept, ram_we, accept && (op == OP_WRITE))

endmodule
